// ----- hdl/clcd_pkg.sv -----
// Shared types, command codes and constants for the four-bit character LCD sequencer.
// Used by the front end, the job queue, the strobe back end and the top level.
package clcd_pkg;

   // Command codes of an input item.
   localparam logic [1:0] CmdData     = 2'd0;
   localparam logic [1:0] CmdInstr    = 2'd1;
   localparam logic [1:0] CmdInit     = 2'd2;
   localparam logic [1:0] CmdLocation = 2'd3;

   // Configuration register indexes.
   localparam int CsrIndexWidth = 3;
   localparam logic [CsrIndexWidth-1:0] RegPulse   = 3'd0;
   localparam logic [CsrIndexWidth-1:0] RegGap     = 3'd1;
   localparam logic [CsrIndexWidth-1:0] RegLongGap = 3'd2;
   localparam logic [CsrIndexWidth-1:0] RegPowerup = 3'd3;
   localparam logic [CsrIndexWidth-1:0] RegTwoLine = 3'd4;
   localparam int CsrDataWidth = 16;

   // Reset values of the configuration registers.
   localparam logic [7:0]  PulseReset   = 8'd5;
   localparam logic [15:0] GapReset     = 16'd40;
   localparam logic [15:0] LongGapReset = 16'd1600;
   localparam logic [15:0] PowerupReset = 16'd40000;
   localparam logic        TwoLineReset = 1'b1;

   // Instruction building blocks.
   localparam logic [7:0] InstrFunctionSet = 8'h20;
   localparam logic [7:0] InstrTwoLineBit  = 8'h08;
   localparam logic [7:0] InstrDisplayOff  = 8'h08;
   localparam logic [7:0] InstrClear       = 8'h01;
   localparam logic [7:0] InstrEntryMode   = 8'h04;
   localparam logic [7:0] InstrIncrement   = 8'h02;
   localparam logic [7:0] InstrDisplayCtl  = 8'h08;
   localparam logic [7:0] InstrDisplayOn   = 8'h04;
   localparam logic [7:0] InstrSetAddress  = 8'h80;
   localparam logic [3:0] InitNibbleWake   = 4'h3;
   localparam logic [3:0] InitNibbleFour   = 4'h2;

   // Strobe counts: a byte is two strobes, power-on init is fourteen.
   localparam int StepWidth = 4;
   localparam logic [StepWidth-1:0] ByteLastStep    = 4'd1;
   localparam logic [StepWidth-1:0] InitLastStep    = 4'd13;
   localparam logic [StepWidth-1:0] InitNibbleSteps = 4'd4;
   localparam logic [StepWidth-1:0] InitFourStep    = 4'd3;

   // Job queue between front and back.
   localparam int QueueDepth    = 2;
   localparam int QueuePtrWidth = 1;
   localparam int QueueCntWidth = 2;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] data_byte;
      logic [5:0] column;
      logic       row;
   } req_type;

   typedef struct packed {
      logic [3:0]  nibble;
      logic        reg_select;
      logic [15:0] wait_before_us;
      logic [7:0]  enable_high_us;
      logic [15:0] wait_after_us;
      logic        last;
   } rsp_type;

   // One classified job: either a single byte or the power-on init sequence.
   typedef struct packed {
      logic       is_init;
      logic       reg_select;
      logic [7:0] data_byte;
   } job_type;

   typedef struct packed {
      logic [7:0]  pulse_us;
      logic [15:0] gap_us;
      logic [15:0] long_gap_us;
      logic [15:0] powerup_wait_us;
      logic        two_line;
   } cfg_type;

   // Instruction bytes sent after the init nibbles, in order.
   function automatic logic [7:0] init_byte(input logic [2:0] idx, input logic two_line);
      logic [7:0] b;
      case (idx)
         3'd0:    b = InstrFunctionSet | (two_line ? InstrTwoLineBit : 8'h00);
         3'd1:    b = InstrDisplayOff;
         3'd2:    b = InstrClear;
         3'd3:    b = InstrEntryMode | InstrIncrement;
         default: b = InstrDisplayCtl | InstrDisplayOn;
      endcase
      return b;
   endfunction

endpackage

// ----- hdl/clcd_front.sv -----
// Front end: accepts command items and classifies them into queue jobs.
// Depends on clcd_pkg.
module clcd_front (
   input  logic              req_valid,
   output logic              req_ready,
   input  clcd_pkg::req_type req_data,
   input  logic              queue_full,
   output logic              push,
   output clcd_pkg::job_type push_job
);
   import clcd_pkg::*;

   // An item is taken whenever the queue has room.
   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full;

   // Turn the command into a byte job or an init job.
   always_comb begin
      push_job = '0;
      case (req_data.cmd)
         CmdData: begin
            push_job.reg_select = 1'b1;
            push_job.data_byte  = req_data.data_byte;
         end
         CmdInstr: begin
            push_job.data_byte = req_data.data_byte;
         end
         CmdInit: begin
            push_job.is_init = 1'b1;
         end
         default: begin
            push_job.data_byte = InstrSetAddress | {1'b0, req_data.row, req_data.column};
         end
      endcase
   end

endmodule

// ----- hdl/clcd_queue.sv -----
// Short job queue that decouples the front end from the strobe back end.
// Depends on clcd_pkg.
module clcd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  clcd_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output clcd_pkg::job_type head_job
);
   import clcd_pkg::*;

   job_type                  entry_ff [QueueDepth];
   logic [QueuePtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QueueCntWidth-1:0] count_ff, count_in;

   assign full     = (count_ff == QueueCntWidth'(QueueDepth));
   assign empty    = (count_ff == '0);
   assign head_job = entry_ff[rd_ptr_ff];

   // Pointer and fill-count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff + QueuePtrWidth'(push);
      rd_ptr_in = rd_ptr_ff + QueuePtrWidth'(pop);
      count_in  = count_ff + QueueCntWidth'(push) - QueueCntWidth'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Job storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ----- hdl/clcd_back.sv -----
// Back end: steps through the strobes of the head job, one strobe per cycle while
// the output slot is free or draining, into the output register. Depends on clcd_pkg.
module clcd_back (
   input  logic              clock,
   input  logic              reset,
   input  clcd_pkg::cfg_type cfg,
   input  logic              queue_empty,
   input  clcd_pkg::job_type head_job,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output clcd_pkg::rsp_type rsp_data
);
   import clcd_pkg::*;

   logic [StepWidth-1:0] step_ff, step_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic                 advance;
   logic                 last_step;
   logic                 high_half;
   logic                 init_nibble;
   logic [StepWidth-1:0] init_ofs;
   logic [7:0]           cur_byte;
   logic                 long_wait;
   logic [16:0]          long_sum;
   logic [15:0]          byte_after;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A strobe is produced when a job waits and the output slot is free or draining.
   assign advance   = !queue_empty && (!rsp_valid_ff || rsp_ready);
   assign last_step = (step_ff == (head_job.is_init ? InitLastStep : ByteLastStep));
   assign pop       = advance && last_step;

   // Work out which byte and which half this step sends.
   always_comb begin
      init_ofs    = step_ff - InitNibbleSteps;
      init_nibble = head_job.is_init && (step_ff < InitNibbleSteps);
      if (head_job.is_init) begin
         cur_byte  = init_byte(init_ofs[3:1], cfg.two_line);
         high_half = !init_ofs[0];
      end else begin
         cur_byte  = head_job.data_byte;
         high_half = !step_ff[0];
      end
      long_wait = !head_job.reg_select && (cur_byte inside {[8'd1:8'd3]});
      long_sum  = {1'b0, cfg.gap_us} + {1'b0, cfg.long_gap_us};
      if (!long_wait) begin
         byte_after = cfg.gap_us;
      end else if (long_sum[16]) begin
         byte_after = 16'hFFFF;
      end else begin
         byte_after = long_sum[15:0];
      end
   end

   // Next output strobe.
   always_comb begin
      rsp_data_in                = rsp_data_ff;
      rsp_data_in.reg_select     = head_job.reg_select;
      rsp_data_in.enable_high_us = (cfg.pulse_us == 8'd0) ? 8'd1 : cfg.pulse_us;
      rsp_data_in.wait_before_us = '0;
      rsp_data_in.last           = last_step;
      if (init_nibble) begin
         rsp_data_in.nibble        = (step_ff == InitFourStep) ? InitNibbleFour
                                                                : InitNibbleWake;
         rsp_data_in.wait_after_us = cfg.gap_us;
         if (step_ff == '0) begin
            rsp_data_in.wait_before_us = cfg.powerup_wait_us;
         end
      end else if (high_half) begin
         rsp_data_in.nibble        = cur_byte[7:4];
         rsp_data_in.wait_after_us = '0;
      end else begin
         rsp_data_in.nibble        = cur_byte[3:0];
         rsp_data_in.wait_after_us = byte_after;
      end
   end

   // Step counter and output valid.
   always_comb begin
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         step_in      = last_step ? '0 : step_ff + 4'd1;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// ----- hdl/char_lcd_four_bit_sequencer.sv -----
// Top level of the four-bit character LCD strobe sequencer.
// Depends on clcd_pkg, clcd_front, clcd_queue and clcd_back.
//
// Each accepted item is a command (data byte, instruction byte, power-on
// init or set cursor location) and yields a run of enable strobes on the
// rsp channel: two for a byte command, fourteen for power-on init, with
// last set on the final strobe. The back end issues one strobe per clock
// cycle while rsp_ready is high; that strobe stepper is the rate-setting
// unit. A two-entry job queue lets new commands be accepted while earlier
// ones are still being sent. Timing registers are written through the csr
// port and should only be changed while no command is in flight.
module char_lcd_four_bit_sequencer (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  clcd_pkg::req_type                      req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output clcd_pkg::rsp_type                      rsp_data,
   input  logic                                   csr_write,
   input  logic [clcd_pkg::CsrIndexWidth-1:0]     csr_index,
   input  logic [clcd_pkg::CsrDataWidth-1:0]      csr_wdata
);
   import clcd_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    queue_full;
   logic    queue_empty;
   logic    push;
   logic    pop;
   job_type push_job;
   job_type head_job;

   // Configuration register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            RegPulse:   cfg_in.pulse_us        = csr_wdata[7:0];
            RegGap:     cfg_in.gap_us          = csr_wdata;
            RegLongGap: cfg_in.long_gap_us     = csr_wdata;
            RegPowerup: cfg_in.powerup_wait_us = csr_wdata;
            RegTwoLine: cfg_in.two_line        = csr_wdata[0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pulse_us        <= PulseReset;
         cfg_ff.gap_us          <= GapReset;
         cfg_ff.long_gap_us     <= LongGapReset;
         cfg_ff.powerup_wait_us <= PowerupReset;
         cfg_ff.two_line        <= TwoLineReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Command classification.
   clcd_front u_front (
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push       (push),
      .push_job   (push_job)
   );

   // Job queue.
   clcd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (queue_full),
      .pop      (pop),
      .empty    (queue_empty),
      .head_job (head_job)
   );

   // Strobe generation.
   clcd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .queue_empty (queue_empty),
      .head_job    (head_job),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

// ----- sim/clcd_strobe_checker.sv -----
`timescale 1ns / 100ps
// Strobe checker for the four-bit character LCD sequencer: predicts the strobes of
// each accepted command and compares them with the rsp channel. Depends on clcd_pkg.
module clcd_strobe_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  clcd_pkg::req_type                   req_data,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  clcd_pkg::rsp_type                   rsp_data,
   input  logic                                csr_write,
   input  logic [clcd_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [clcd_pkg::CsrDataWidth-1:0]   csr_wdata,
   output int                                  mismatch_count,
   output int                                  strobes_outstanding
);
   import clcd_pkg::*;

   // Local copy of the timing registers and the strobes still owed by the block.
   cfg_type timing;
   rsp_type expected_strobes[$];

   function automatic rsp_type strobe(input logic [3:0] nib, input logic rs,
                                      input logic [15:0] wait_pre, input logic [15:0] after,
                                      input logic fin);
      rsp_type s;
      s.nibble         = nib;
      s.reg_select     = rs;
      s.wait_before_us = wait_pre;
      // A zero pulse register still gives the shortest legal enable pulse.
      s.enable_high_us = (timing.pulse_us == 8'd0) ? 8'd1 : timing.pulse_us;
      s.wait_after_us  = after;
      s.last           = fin;
      return s;
   endfunction

   // A byte goes out as high nibble then low nibble; the wait follows the low one.
   task automatic push_byte(input logic [7:0] b, input logic rs, input logic fin);
      logic [16:0] sum;
      logic [15:0] after;
      sum   = {1'b0, timing.gap_us} + {1'b0, timing.long_gap_us};
      after = timing.gap_us;
      // Clear and home instructions need the long wait, saturated at the top.
      if (!rs && b >= 8'd1 && b <= 8'd3)
         after = sum[16] ? 16'hFFFF : sum[15:0];
      expected_strobes.push_back(strobe(b[7:4], rs, 16'd0, 16'd0, 1'b0));
      expected_strobes.push_back(strobe(b[3:0], rs, 16'd0, after, fin));
   endtask

   task automatic predict_strobes(input req_type item);
      case (item.cmd)
         CmdData:  push_byte(item.data_byte, 1'b1, 1'b1);
         CmdInstr: push_byte(item.data_byte, 1'b0, 1'b1);
         CmdInit: begin
            // Wake-up nibbles, the first one after the power-up wait.
            expected_strobes.push_back(strobe(InitNibbleWake, 1'b0, timing.powerup_wait_us,
                                              timing.gap_us, 1'b0));
            repeat (2)
               expected_strobes.push_back(strobe(InitNibbleWake, 1'b0, 16'd0,
                                                 timing.gap_us, 1'b0));
            expected_strobes.push_back(strobe(InitNibbleFour, 1'b0, 16'd0, timing.gap_us, 1'b0));
            push_byte(InstrFunctionSet | (timing.two_line ? InstrTwoLineBit : 8'h00), 1'b0, 1'b0);
            push_byte(InstrDisplayOff, 1'b0, 1'b0);
            push_byte(InstrClear, 1'b0, 1'b0);
            push_byte(InstrEntryMode | InstrIncrement, 1'b0, 1'b0);
            push_byte(InstrDisplayCtl | InstrDisplayOn, 1'b0, 1'b1);
         end
         default: push_byte(InstrSetAddress | {1'b0, item.row, item.column}, 1'b0, 1'b1);
      endcase
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count = mismatch_count + 1;
      end
   endtask

   // Everything is sampled at the rising edge, before the block's outputs move.
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         timing.pulse_us        = PulseReset;
         timing.gap_us          = GapReset;
         timing.long_gap_us     = LongGapReset;
         timing.powerup_wait_us = PowerupReset;
         timing.two_line        = TwoLineReset;
         expected_strobes.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_strobes.size() == 0) begin
               $error("strobe %h arrived with none expected", rsp_data);
               mismatch_count = mismatch_count + 1;
            end else begin
               want = expected_strobes.pop_front();
               check_field("nibble", 16'(want.nibble), 16'(rsp_data.nibble));
               check_field("reg_select", 16'(want.reg_select), 16'(rsp_data.reg_select));
               check_field("wait_before_us", want.wait_before_us, rsp_data.wait_before_us);
               check_field("enable_high_us", 16'(want.enable_high_us),
                           16'(rsp_data.enable_high_us));
               check_field("wait_after_us", want.wait_after_us, rsp_data.wait_after_us);
               check_field("last", 16'(want.last), 16'(rsp_data.last));
            end
         end
         if (req_valid && req_ready)
            predict_strobes(req_data);
         // Writes to indexes past the last register change nothing.
         if (csr_write) begin
            case (csr_index)
               RegPulse:   timing.pulse_us        = csr_wdata[7:0];
               RegGap:     timing.gap_us          = csr_wdata;
               RegLongGap: timing.long_gap_us     = csr_wdata;
               RegPowerup: timing.powerup_wait_us = csr_wdata;
               RegTwoLine: timing.two_line        = csr_wdata[0];
               default: ;
            endcase
         end
      end
      strobes_outstanding = expected_strobes.size();
   end

endmodule

// ----- sim/char_lcd_four_bit_sequencer_tb.sv -----
`timescale 1ns / 100ps
// Top of the four-bit character LCD sequencer testbench: clock, reset, commands,
// register writes and random stalls. Depends on clcd_pkg and clcd_strobe_checker.
module char_lcd_four_bit_sequencer_tb;
   import clcd_pkg::*;

   // Indexes past the last register; writes there must be ignored.
   localparam logic [CsrIndexWidth-1:0] RegFirstSpare = 3'd5;
   localparam logic [CsrIndexWidth-1:0] RegLastSpare  = 3'd7;
   localparam int ItemsPerPhase = 100;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   req_type                  req_data;
   logic                     rsp_valid;
   logic                     rsp_ready;
   rsp_type                  rsp_data;
   logic                     csr_write;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0]  csr_wdata;
   int                       mismatch_count;
   int                       strobes_outstanding;
   int                       send_idle_pct;
   int                       take_idle_pct;

   char_lcd_four_bit_sequencer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   clcd_strobe_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_data            (req_data),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_data            (rsp_data),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .mismatch_count      (mismatch_count),
      .strobes_outstanding (strobes_outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // The display side stalls at random; the rate changes per phase.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready = ($urandom_range(0, 99) >= take_idle_pct);
      end
   end

   // A correct run needs well under a tenth of this.
   initial begin
      #2000000;
      $display("Some tests failed");
      $finish;
   end

   function automatic req_type cmd_item(input logic [1:0] cmd, input logic [7:0] b,
                                        input logic [5:0] col, input logic row);
      req_type item;
      item.cmd       = cmd;
      item.data_byte = b;
      item.column    = col;
      item.row       = row;
      return item;
   endfunction

   function automatic req_type random_cmd();
      req_type item;
      int roll;
      item.data_byte = 8'($urandom);
      item.column    = 6'($urandom);
      item.row       = 1'($urandom);
      roll = $urandom_range(0, 99);
      if (roll < 8)
         item.cmd = CmdInit;
      else if (roll < 40)
         item.cmd = CmdData;
      else if (roll < 75)
         item.cmd = CmdInstr;
      else
         item.cmd = CmdLocation;
      // Clear and home carry the long wait, so make them common among instructions.
      if (item.cmd == CmdInstr && $urandom_range(0, 3) == 0)
         item.data_byte = 8'($urandom_range(1, 3));
      return item;
   endfunction

   task automatic write_reg(input logic [CsrIndexWidth-1:0] idx,
                            input logic [CsrDataWidth-1:0] value);
      @(negedge clock);
      csr_write = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_write = 1'b0;
   endtask

   // Offer one item after a random gap and hold it until it is taken.
   task automatic send_cmd(input req_type item);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = item;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   // Stop sending and wait until every predicted strobe has come back.
   task automatic wait_for_strobes();
      @(negedge clock);
      req_valid = 1'b0;
      while (strobes_outstanding != 0)
         @(negedge clock);
   endtask

   task automatic randomize_timing();
      write_reg(RegPulse, 16'($urandom));
      write_reg(RegGap, 16'($urandom));
      write_reg(RegLongGap, 16'($urandom));
      write_reg(RegPowerup, 16'($urandom));
      write_reg(RegTwoLine, 16'($urandom));
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      csr_write     = 1'b0;
      csr_index     = RegPulse;
      csr_wdata     = '0;
      send_idle_pct = 27;
      take_idle_pct = 64;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset timing: init, byte extremes, clear and home, cursor corners.
      // Unused fields carry junk that must not leak into the strobes.
      send_cmd(cmd_item(CmdInit, 8'hC3, 6'h2A, 1'b1));
      send_cmd(cmd_item(CmdData, 8'h00, 6'h3F, 1'b1));
      send_cmd(cmd_item(CmdData, 8'hFF, 6'h00, 1'b0));
      send_cmd(cmd_item(CmdData, 8'hA5, 6'h15, 1'b1));
      send_cmd(cmd_item(CmdInstr, 8'h00, 6'h3F, 1'b1));
      send_cmd(cmd_item(CmdInstr, 8'h01, 6'h00, 1'b0));
      send_cmd(cmd_item(CmdInstr, 8'h02, 6'h2A, 1'b1));
      send_cmd(cmd_item(CmdInstr, 8'h03, 6'h15, 1'b0));
      send_cmd(cmd_item(CmdInstr, 8'h04, 6'h3F, 1'b1));
      send_cmd(cmd_item(CmdInstr, 8'hFF, 6'h00, 1'b0));
      send_cmd(cmd_item(CmdLocation, 8'hFF, 6'h00, 1'b0));
      send_cmd(cmd_item(CmdLocation, 8'h00, 6'h3F, 1'b1));
      send_cmd(cmd_item(CmdLocation, 8'h5A, 6'h15, 1'b0));
      wait_for_strobes();

      // Zero pulse, long wait saturating, longest power-up, one-line init.
      write_reg(RegPulse, 16'h0000);
      write_reg(RegGap, 16'hFFFF);
      write_reg(RegLongGap, 16'h0001);
      write_reg(RegPowerup, 16'hFFFF);
      write_reg(RegTwoLine, 16'h0000);
      send_cmd(cmd_item(CmdInit, 8'h3C, 6'h15, 1'b0));
      send_cmd(cmd_item(CmdInstr, 8'h01, 6'h00, 1'b0));
      send_cmd(cmd_item(CmdData, 8'h5A, 6'h3F, 1'b1));
      wait_for_strobes();

      // Longest pulse, no gaps at all but the long one, upper data bits set.
      write_reg(RegPulse, 16'hFFFF);
      write_reg(RegGap, 16'h0000);
      write_reg(RegLongGap, 16'hFFFF);
      write_reg(RegPowerup, 16'h0000);
      write_reg(RegTwoLine, 16'h0001);
      send_cmd(cmd_item(CmdInit, 8'hFF, 6'h3F, 1'b1));
      send_cmd(cmd_item(CmdInstr, 8'h03, 6'h2A, 1'b1));
      send_cmd(cmd_item(CmdLocation, 8'h00, 6'h3F, 1'b1));
      wait_for_strobes();

      // Writes past the last register must leave the timing alone.
      for (int idx = RegFirstSpare; idx <= RegLastSpare; idx++)
         write_reg(idx[CsrIndexWidth-1:0], 16'($urandom));
      send_cmd(cmd_item(CmdData, 8'h3C, 6'h00, 1'b0));
      send_cmd(cmd_item(CmdInstr, 8'h02, 6'h15, 1'b1));

      // Random commands under three stall patterns, fresh timing each time.
      for (int phase = 0; phase < 3; phase++) begin
         wait_for_strobes();
         randomize_timing();
         case (phase)
            0: begin
               send_idle_pct = 27;
               take_idle_pct = 64;
            end
            1: begin
               send_idle_pct = 64;
               take_idle_pct = 27;
            end
            default: begin
               send_idle_pct = 0;
               take_idle_pct = 0;
            end
         endcase
         for (int n = 0; n < ItemsPerPhase; n++) begin
            send_cmd(random_cmd());
            // Let the pipeline run dry once in the middle of each phase.
            if (n == ItemsPerPhase / 2)
               wait_for_strobes();
         end
      end

      wait_for_strobes();
      repeat (20) @(negedge clock);
      if (mismatch_count == 0 && strobes_outstanding == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
